FILE: design/dvi_lane_deskew_sync_extract_defines.svh
// Assertion macros for the DVI lane deskew and sync extract block.
// No dependencies; taken in by the top level with an include.
`ifndef DVI_LANE_DESKEW_SYNC_EXTRACT_DEFINES_SVH
`define DVI_LANE_DESKEW_SYNC_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock outside reset
`define DSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock outside reset
`define DSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define DSK_ASSERT_NOW(label, ante, cons, msg)
`define DSK_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: design/dvi_dsk_pkg.sv
// Shared constants, character and control types for the DVI lane deskew block.
// No dependencies; imported by every module of the block.
package dvi_dsk_pkg;

    // Deskew window and pixel counter size
    localparam int SKEW_WINDOW = 50;
    localparam int COUNT_BITS  = 16;

    // History geometry: ages 0 .. 2*window, candidate ages 0 .. 2*window-1
    localparam int HIST_LEN  = 2 * SKEW_WINDOW + 1;
    localparam int NUM_CAND  = 2 * SKEW_WINDOW;
    localparam int AGE_W     = $clog2(HIST_LEN);
    localparam int GRP_N     = 8;
    localparam int GRP_W     = $clog2(GRP_N);
    localparam int CAND_GRPS = (NUM_CAND + GRP_N - 1) / GRP_N;
    localparam int READ_GRPS = (HIST_LEN + GRP_N - 1) / GRP_N;

    localparam int KIND_W = 2;
    localparam int VAL_W  = 8;
    localparam int WIDE_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Pixel counter ceiling
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Character type codes
    typedef enum logic [KIND_W-1:0] {
        KIND_CTRL  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERR   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Result class codes
    typedef enum logic [2:0] {
        CLS_BLANK = 3'd0,
        CLS_HSYNC = 3'd1,
        CLS_VSYNC = 3'd2,
        CLS_VIDEO = 3'd3,
        CLS_ERROR = 3'd4
    } t_class;

    // One lane character
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
    } t_char;

    // Sequencer strobes to a lane history
    typedef struct packed {
        logic shift;   // new item enters the chain
        logic scan;    // register per-group edge search
        logic pick;    // adopt the earliest edge as the new offset
        logic gather;  // register per-group read at the current offset
    } t_lane_ctl;

endpackage

FILE: design/dvi_dsk_cell.sv
// One stage of a character chain: holds a character and its valid flag.
// Depends on dvi_dsk_pkg for the character type.
module dvi_dsk_cell import dvi_dsk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_char i_char,
    input  logic  i_valid,
    output t_char o_char,
    output logic  o_valid
);

    t_char r_char;
    logic  r_valid;

    // Payload moves on each shift, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_char <= i_char;
        end
    end

    // Valid flag marks an entry that has really been written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    assign o_char  = r_char;
    assign o_valid = r_valid;

endmodule

FILE: design/dvi_dsk_lane.sv
// Deskew history for one of the green or red lanes: a chain of cells, the
// offset register, the registered edge search and the registered offset read.
// Depends on dvi_dsk_pkg and dvi_dsk_cell.
module dvi_dsk_lane import dvi_dsk_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_ctl        i_ctl,
    input  t_char            i_char,
    output logic [VAL_W-1:0] o_value
);

    t_char                  w_char [HIST_LEN];
    logic                   w_vld  [HIST_LEN];
    logic [CAND_GRPS*GRP_N-1:0] w_cand;
    logic [VAL_W-1:0]       w_val  [READ_GRPS*GRP_N];

    // Age of the entry currently aligned with blue; window centre at reset
    logic [AGE_W-1:0]       r_age;
    logic [CAND_GRPS-1:0]   r_gfnd;
    logic [GRP_W-1:0]       r_gidx [CAND_GRPS];
    logic [CAND_GRPS-1:0]   n_gfnd;
    logic [GRP_W-1:0]       n_gidx [CAND_GRPS];
    logic                   w_found;
    logic [AGE_W-1:0]       w_new_age;
    logic [VAL_W-1:0]       r_rg   [READ_GRPS];
    logic [VAL_W-1:0]       n_rg   [READ_GRPS];

    // Chain of history cells, age 0 is the newest character
    genvar g;
    generate
        for (g = 0; g < HIST_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                dvi_dsk_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_ctl.shift),
                    .i_char  (i_char),
                    .i_valid (1'b1),
                    .o_char  (w_char[g]),
                    .o_valid (w_vld[g])
                );
            end else begin : g_body
                dvi_dsk_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (i_ctl.shift),
                    .i_char  (w_char[g-1]),
                    .i_valid (w_vld[g-1]),
                    .o_char  (w_char[g]),
                    .o_valid (w_vld[g])
                );
            end
        end
    endgenerate

    // Candidate flags: control followed by data, predecessor written,
    // and within one window of the current offset
    always_comb begin
        w_cand = '0;
        for (int a = 0; a < NUM_CAND; a++) begin
            w_cand[a] = w_vld[a+1]
                     && (w_char[a+1].kind == KIND_CTRL)
                     && (w_char[a].kind == KIND_DATA)
                     && (int'(r_age) + SKEW_WINDOW >= a)
                     && (int'(r_age) <= a + SKEW_WINDOW);
        end
    end

    // Per-group search: the oldest candidate in each group wins
    always_comb begin
        for (int k = 0; k < CAND_GRPS; k++) begin
            n_gfnd[k] = 1'b0;
            n_gidx[k] = '0;
            for (int j = 0; j < GRP_N; j++) begin
                if (w_cand[k*GRP_N + j]) begin
                    n_gfnd[k] = 1'b1;
                    n_gidx[k] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_gfnd <= n_gfnd;
            r_gidx <= n_gidx;
        end
    end

    // Across groups: the oldest group holding a candidate wins
    always_comb begin
        w_found   = 1'b0;
        w_new_age = r_age;
        for (int k = 0; k < CAND_GRPS; k++) begin
            if (r_gfnd[k]) begin
                w_found   = 1'b1;
                w_new_age = AGE_W'(k * GRP_N) + AGE_W'(r_gidx[k]);
            end
        end
    end

    // Offset register; kept when no candidate qualifies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= AGE_W'(SKEW_WINDOW);
        end else if (i_ctl.pick && w_found) begin
            r_age <= w_new_age;
        end
    end

    // Values padded to whole read groups
    always_comb begin
        for (int a = 0; a < READ_GRPS*GRP_N; a++) begin
            w_val[a] = '0;
        end
        for (int a = 0; a < HIST_LEN; a++) begin
            w_val[a] = w_char[a].value;
        end
    end

    // Per-group read at the aligned age
    always_comb begin
        for (int k = 0; k < READ_GRPS; k++) begin
            n_rg[k] = '0;
            for (int j = 0; j < GRP_N; j++) begin
                if (int'(r_age) == k*GRP_N + j) begin
                    n_rg[k] = n_rg[k] | w_val[k*GRP_N + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.gather) begin
            r_rg <= n_rg;
        end
    end

    // Only the group holding the aligned age is non-zero
    always_comb begin
        o_value = '0;
        for (int k = 0; k < READ_GRPS; k++) begin
            o_value = o_value | r_rg[k];
        end
    end

endmodule

FILE: design/dvi_lane_deskew_sync_extract.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_blue/green/red_kind, i_*_value
// result    out        o_valid / i_ready   o_symbol_class .. o_vsync_event
//
// Each item passes through the transfer, the group edge search, the offset
// pick, the group read and the result build in turn, set by the registered
// two-level search and read over the 101-entry lane histories.
// Reset (synchronous, active low) empties the chains and recentres both offsets.
// A finished result waits in the output register while the next item is taken;
// the result build holds only if that register is still full.
// Depends on dvi_dsk_pkg, dvi_dsk_cell, dvi_dsk_lane and the defines header.
`include "dvi_lane_deskew_sync_extract_defines.svh"

module dvi_lane_deskew_sync_extract import dvi_dsk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_blue_kind,
    input  logic [7:0]   i_blue_value,
    input  logic [1:0]   i_green_kind,
    input  logic [7:0]   i_green_value,
    input  logic [1:0]   i_red_kind,
    input  logic [7:0]   i_red_value,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [2:0]   o_symbol_class,
    output logic         o_extends_run,
    output logic [7:0]   o_pixel_red,
    output logic [7:0]   o_pixel_green,
    output logic [7:0]   o_pixel_blue,
    output logic         o_line_start,
    output logic         o_line_end,
    output logic [15:0]  o_line_width,
    output logic         o_vsync_event
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_PICK   = 5'b00100,
        S_GATHER = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept, w_out_free, w_load, w_realign;

    t_char  w_bchar [SKEW_WINDOW+1];
    logic   w_bvld  [SKEW_WINDOW+1];
    t_char  w_bch;
    logic   w_has_res;
    t_char  w_blue_in, w_green_in, w_red_in;

    t_lane_ctl        w_ctl_g, w_ctl_r;
    logic [VAL_W-1:0] w_green_val, w_red_val;

    // Sync decode state
    logic [KIND_W-1:0]     r_prev_kind, n_prev_kind;
    t_char                 r_prev_char;
    logic                  r_any, n_any;
    logic                  r_open, n_open;
    logic [COUNT_BITS-1:0] r_pix, n_pix;
    logic [WIDE_W-1:0]     w_pix_wide;

    // Output register
    logic         r_ovalid;
    t_class       r_cls, n_cls;
    logic         r_ext, n_ext;
    logic [7:0]   r_pr, n_pr, r_pg, n_pg, r_pb, n_pb;
    logic         r_ls, n_ls, r_le, n_le, r_vs, n_vs;
    logic [15:0]  r_lw, n_lw;

    assign w_blue_in  = '{kind: i_blue_kind,  value: i_blue_value};
    assign w_green_in = '{kind: i_green_kind, value: i_green_value};
    assign w_red_in   = '{kind: i_red_kind,   value: i_red_value};

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    // Blue delay chain; the last cell holds the character aligned at offset zero
    genvar g;
    generate
        for (g = 0; g <= SKEW_WINDOW; g++) begin : g_blue
            if (g == 0) begin : g_head
                dvi_dsk_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_char  (w_blue_in),
                    .i_valid (1'b1),
                    .o_char  (w_bchar[g]),
                    .o_valid (w_bvld[g])
                );
            end else begin : g_body
                dvi_dsk_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_accept),
                    .i_char  (w_bchar[g-1]),
                    .i_valid (w_bvld[g-1]),
                    .o_char  (w_bchar[g]),
                    .o_valid (w_bvld[g])
                );
            end
        end
    endgenerate

    assign w_bch     = w_bchar[SKEW_WINDOW];
    assign w_has_res = w_bvld[SKEW_WINDOW];

    // Realign on a blue control-to-data edge
    assign w_realign = w_has_res && (w_bch.kind == KIND_DATA)
                    && (r_prev_kind == KIND_CTRL);

    always_comb begin
        w_ctl_g.shift  = w_accept;
        w_ctl_g.scan   = (r_state == S_SCAN);
        w_ctl_g.pick   = (r_state == S_PICK) && w_realign;
        w_ctl_g.gather = (r_state == S_GATHER);
        w_ctl_r        = w_ctl_g;
    end

    dvi_dsk_lane u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_g),
        .i_char  (w_green_in),
        .o_value (w_green_val)
    );

    dvi_dsk_lane u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_r),
        .i_char  (w_red_in),
        .o_value (w_red_val)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   n_state = S_PICK;
            S_PICK:   n_state = S_GATHER;
            S_GATHER: n_state = S_EMIT;
            S_EMIT: begin
                if (!w_has_res) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Saturated width for the closed scanline
    assign w_pix_wide = WIDE_W'(r_pix);

    // Blue classification and scanline tracking
    always_comb begin
        n_cls       = CLS_ERROR;
        n_ext       = 1'b0;
        n_pr        = '0;
        n_pg        = '0;
        n_pb        = '0;
        n_ls        = 1'b0;
        n_le        = 1'b0;
        n_lw        = '0;
        n_vs        = 1'b0;
        n_open      = r_open;
        n_pix       = r_pix;
        n_any       = r_any;
        n_prev_kind = w_bch.kind;
        case (w_bch.kind)
            KIND_CTRL: begin
                if ((r_prev_kind == KIND_DATA) && r_open) begin
                    n_le   = 1'b1;
                    n_lw   = (w_pix_wide > WIDE_W'(16'hFFFF)) ? 16'hFFFF
                                                              : w_pix_wide[15:0];
                    n_pix  = '0;
                    n_open = 1'b0;
                end
                if (w_bch.value[1]) begin
                    n_cls = CLS_VSYNC;
                end else if (w_bch.value[0]) begin
                    n_cls = CLS_HSYNC;
                end else begin
                    n_cls = CLS_BLANK;
                end
                if (r_any && (r_prev_char == w_bch)) begin
                    n_ext = 1'b1;
                end else if (w_bch.value[1]) begin
                    n_vs = 1'b1;
                end
                n_any = 1'b1;
            end
            KIND_DATA: begin
                if (r_prev_kind == KIND_CTRL) begin
                    n_open = 1'b1;
                    n_pix  = '0;
                    n_ls   = 1'b1;
                end
                n_cls = CLS_VIDEO;
                n_pr  = w_red_val;
                n_pg  = w_green_val;
                n_pb  = w_bch.value;
                if (n_open && (n_pix != CNT_MAX)) begin
                    n_pix = n_pix + 1'b1;
                end
                n_any = 1'b1;
            end
            default: ;
        endcase
    end

    // Decode state moves once per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kind <= KIND_ERR;
            r_prev_char <= '0;
            r_any       <= 1'b0;
            r_open      <= 1'b0;
            r_pix       <= '0;
        end else if (w_load) begin
            r_prev_kind <= n_prev_kind;
            r_prev_char <= w_bch;
            r_any       <= n_any;
            r_open      <= n_open;
            r_pix       <= n_pix;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cls <= n_cls;
            r_ext <= n_ext;
            r_pr  <= n_pr;
            r_pg  <= n_pg;
            r_pb  <= n_pb;
            r_ls  <= n_ls;
            r_le  <= n_le;
            r_lw  <= n_lw;
            r_vs  <= n_vs;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_symbol_class = r_cls;
    assign o_extends_run  = r_ext;
    assign o_pixel_red    = r_pr;
    assign o_pixel_green  = r_pg;
    assign o_pixel_blue   = r_pb;
    assign o_line_start   = r_ls;
    assign o_line_end     = r_le;
    assign o_line_width   = r_lw;
    assign o_vsync_event  = r_vs;

    // Checks
    `DSK_ASSERT_NEXT(a_busy_after_transfer, w_accept, !o_ready, "input taken while busy")
    `DSK_ASSERT_NOW(a_width_with_end, o_valid && !o_line_end, o_line_width == 16'd0, "width without line end")
    `DSK_ASSERT_NOW(a_pixels_only_video, o_valid && (o_symbol_class != CLS_VIDEO), (o_pixel_red == 8'd0) && (o_pixel_green == 8'd0) && (o_pixel_blue == 8'd0) && !o_line_start, "pixel fields outside video")

endmodule
